[rtl/core/two_region_first_fit_block_allocator_core_defines.svh]
// ----------------------------------------------------------------------------
// two-region first-fit block allocator: assertion macros
// shared concurrent assertion forms for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef TWO_REGION_FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define TWO_REGION_FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define TFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define TFBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/core/tfba_pkg.sv]
// ----------------------------------------------------------------------------
// tfba_pkg
// item types, command and status codes, default sizes of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

package tfba_pkg;

  localparam int TOTAL_BLOCKS_DEF    = 1024;
  localparam int REALTIME_BLOCKS_DEF = 64;
  localparam int PID_WIDTH_DEF       = 8;

  // commands
  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_ALLOC  = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;
  localparam logic [1:0] CMD_LOCATE = 2'd3;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_TOO_BIG   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  process_id;
    logic [10:0] block_count;
    logic        user_class;
    logic [9:0]  start_block;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] found_block;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/tfba_ram.sv]
// ----------------------------------------------------------------------------
// tfba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tfba_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/two_region_first_fit_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// two_region_first_fit_block_allocator_core
// owner map of memory blocks with first-fit find, allocate, free and locate
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid / in_ready / in_item, one command per item
//   out channel : out_valid / out_ready / out_item, exactly one result per item
//   the owner map sits in one ram of TOTAL_BLOCKS entries, walked one entry
//   per cycle by a small sequencer; one item is worked on at a time
// work per item
//   find / locate : one ram entry read per scanned block, at most
//                   TOTAL_BLOCKS; set by the single ram read port, one entry per cycle
//   allocate/free : one ram write per block written, one ram write per cycle
//   find rejected for size or zero length : no ram access, straight to the result
// reset
//   rst_n low clears control state; afterwards a clearing pass over all
//   TOTAL_BLOCKS entries marks every block free, in_ready stays low meanwhile
// stalls
//   a finished result waits in the output register; the next item is still
//   accepted and worked on, and its result waits until out_ready frees the
//   register
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_region_first_fit_block_allocator_core_defines.svh"

module two_region_first_fit_block_allocator_core #(
  parameter int TOTAL_BLOCKS    = tfba_pkg::TOTAL_BLOCKS_DEF,
  parameter int REALTIME_BLOCKS = tfba_pkg::REALTIME_BLOCKS_DEF,
  parameter int PID_WIDTH       = tfba_pkg::PID_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tfba_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tfba_pkg::out_item_t     out_item
);

  // widths: AW addresses the map, CW also holds TOTAL_BLOCKS,
  // SW holds start + count of an item
  localparam int AW      = $clog2(TOTAL_BLOCKS);
  localparam int CW      = $clog2(TOTAL_BLOCKS + 1);
  localparam int SW      = (CW > 12) ? CW : 12;
  localparam int MW      = PID_WIDTH + 1;
  localparam int RT_SIZE = (REALTIME_BLOCKS < TOTAL_BLOCKS) ? REALTIME_BLOCKS : TOTAL_BLOCKS;

  localparam logic [CW-1:0] RT_C     = CW'(RT_SIZE);
  localparam logic [CW-1:0] TB_C     = CW'(TOTAL_BLOCKS);
  localparam logic [SW-1:0] TB_S     = SW'(TOTAL_BLOCKS);
  localparam logic [SW-1:0] RT_LEN_S = SW'(RT_SIZE);
  localparam logic [SW-1:0] US_LEN_S = SW'(TOTAL_BLOCKS - RT_SIZE);
  localparam logic [AW-1:0] LAST_A   = AW'(TOTAL_BLOCKS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FILL  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  // control
  state_t              state_r,     state_nxt;
  logic [AW-1:0]       clr_ptr_r,   clr_ptr_nxt;
  logic                rd_valid_r,  rd_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  // working registers of the current item
  logic [CW-1:0]       cur_r,       cur_nxt;
  logic [CW-1:0]       end_r,       end_nxt;
  logic [CW-1:0]       size_r,      size_nxt;
  logic [CW-1:0]       run_r,       run_nxt;
  logic [CW-1:0]       first_r,     first_nxt;
  logic [CW-1:0]       rd_idx_r,    rd_idx_nxt;
  logic [MW-1:0]       fill_val_r,  fill_val_nxt;
  logic [PID_WIDTH-1:0] pid_r,      pid_nxt;
  logic                is_locate_r, is_locate_nxt;
  logic [1:0]          pend_status_r, pend_status_nxt;
  logic [9:0]          pend_found_r,  pend_found_nxt;
  tfba_pkg::out_item_t out_item_r,  out_item_nxt;

  // ram port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [MW-1:0]       ram_rdata;

  // decode helpers
  logic [PID_WIDTH-1:0] in_pid;
  logic [SW-1:0]        in_count_s;
  logic [SW-1:0]        in_start_s;
  logic [SW-1:0]        range_sum;
  logic [SW-1:0]        range_end;
  logic [SW-1:0]        region_len;
  logic                 issue;
  logic                 last_idx;
  logic [CW-1:0]        run_inc;
  logic                 slot_free;

  tfba_ram #(
    .WIDTH (MW),
    .DEPTH (TOTAL_BLOCKS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign in_pid     = PID_WIDTH'(in_item.process_id);
  assign in_count_s = SW'(in_item.block_count);
  assign in_start_s = SW'(in_item.start_block);
  // fill and clear ranges stop at the end of the map
  assign range_sum  = in_start_s + in_count_s;
  assign range_end  = (range_sum > TB_S) ? TB_S : range_sum;
  assign region_len = in_item.user_class ? US_LEN_S : RT_LEN_S;

  // scan pipeline: one read issued per cycle, its data evaluated in the next cycle
  assign issue     = (state_r == S_SCAN) && (cur_r < end_r);
  assign last_idx  = ((rd_idx_r + CW'(1)) == end_r);
  assign run_inc   = run_r + CW'(1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    clr_ptr_nxt     = clr_ptr_r;
    rd_valid_nxt    = 1'b0;
    out_valid_nxt   = out_valid_r;
    cur_nxt         = cur_r;
    end_nxt         = end_r;
    size_nxt        = size_r;
    run_nxt         = run_r;
    first_nxt       = first_r;
    rd_idx_nxt      = cur_r;
    fill_val_nxt    = fill_val_r;
    pid_nxt         = pid_r;
    is_locate_nxt   = is_locate_r;
    pend_status_nxt = pend_status_r;
    pend_found_nxt  = pend_found_r;
    out_item_nxt    = out_item_r;
    ram_we          = 1'b0;
    ram_waddr       = cur_r[AW-1:0];
    ram_wdata       = fill_val_r;
    ram_raddr       = cur_r[AW-1:0];

    // result register drains on its own handshake
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // mark every block free after reset
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_r;
        ram_wdata = '0;
        clr_ptr_nxt = clr_ptr_r + AW'(1);
        if (clr_ptr_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          pend_status_nxt = tfba_pkg::ST_OK;
          pend_found_nxt  = '0;
          pid_nxt         = in_pid;
          is_locate_nxt   = 1'b0;
          run_nxt         = '0;
          unique case (in_item.command)
            tfba_pkg::CMD_FIND: begin
              cur_nxt   = in_item.user_class ? RT_C : '0;
              first_nxt = in_item.user_class ? RT_C : '0;
              end_nxt   = in_item.user_class ? TB_C : RT_C;
              size_nxt  = CW'(in_item.block_count);
              if (in_count_s > region_len) begin
                pend_status_nxt = tfba_pkg::ST_TOO_BIG;
                state_nxt       = S_RESP;
              end else if (in_count_s == '0) begin
                // an empty request finds nothing
                pend_status_nxt = tfba_pkg::ST_NO_SPACE;
                state_nxt       = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            tfba_pkg::CMD_ALLOC,
            tfba_pkg::CMD_FREE: begin
              cur_nxt      = CW'(in_item.start_block);
              end_nxt      = CW'(range_end);
              fill_val_nxt = (in_item.command == tfba_pkg::CMD_ALLOC) ?
                             {1'b1, in_pid} : '0;
              // empty range or start past the map: nothing to write
              state_nxt    = (in_start_s < range_end) ? S_FILL : S_RESP;
            end
            tfba_pkg::CMD_LOCATE: begin
              cur_nxt       = '0;
              end_nxt       = TB_C;
              is_locate_nxt = 1'b1;
              state_nxt     = S_SCAN;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_FILL: begin
        ram_we  = 1'b1;
        cur_nxt = cur_r + CW'(1);
        if ((cur_r + CW'(1)) == end_r) begin
          state_nxt = S_RESP;
        end
      end

      S_SCAN: begin
        if (issue) begin
          cur_nxt = cur_r + CW'(1);
        end
        rd_valid_nxt = issue;
        if (rd_valid_r) begin
          if (is_locate_r) begin
            if (ram_rdata == {1'b1, pid_r}) begin
              pend_status_nxt = tfba_pkg::ST_OK;
              pend_found_nxt  = 10'(rd_idx_r);
              state_nxt       = S_RESP;
              rd_valid_nxt    = 1'b0;
            end else if (last_idx) begin
              pend_status_nxt = tfba_pkg::ST_NOT_FOUND;
              state_nxt       = S_RESP;
              rd_valid_nxt    = 1'b0;
            end
          end else begin
            if (ram_rdata[MW-1]) begin
              // owned block breaks the run
              first_nxt = rd_idx_r + CW'(1);
              run_nxt   = '0;
            end else begin
              run_nxt = run_inc;
            end
            if (!ram_rdata[MW-1] && (run_inc == size_r)) begin
              pend_status_nxt = tfba_pkg::ST_OK;
              pend_found_nxt  = 10'(first_r);
              state_nxt       = S_RESP;
              rd_valid_nxt    = 1'b0;
            end else if (last_idx) begin
              pend_status_nxt = tfba_pkg::ST_NO_SPACE;
              state_nxt       = S_RESP;
              rd_valid_nxt    = 1'b0;
            end
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = pend_status_r;
          out_item_nxt.found_block = pend_found_r;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    end_r         <= end_nxt;
    size_r        <= size_nxt;
    run_r         <= run_nxt;
    first_r       <= first_nxt;
    rd_idx_r      <= rd_idx_nxt;
    fill_val_r    <= fill_val_nxt;
    pid_r         <= pid_nxt;
    is_locate_r   <= is_locate_nxt;
    pend_status_r <= pend_status_nxt;
    pend_found_r  <= pend_found_nxt;
    out_item_r    <= out_item_nxt;
  end

  // reset always lands in the clearing pass with nothing in flight
  `TFBA_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (state_r == S_CLEAR) && !out_valid_r && !rd_valid_r, "reset did not restart the clearing pass")
  // fill cursor never runs past the saturated range end
  `TFBA_ASSERT(a_fill_in_range, (state_r == S_FILL) |-> (cur_r < end_r), "fill cursor past range end")
  // a find never lets the run grow to the requested size without stopping
  `TFBA_ASSERT(a_run_below_size, ((state_r == S_SCAN) && !is_locate_r) |-> (run_r < size_r), "free run reached size without a hit")
  // returning read data belongs to a live scan and lies inside its region
  `TFBA_ASSERT(a_read_in_scan, rd_valid_r |-> ((state_r == S_SCAN) && (rd_idx_r < end_r)), "read data outside a scan")
  // the map is never written while it is being scanned
  `TFBA_ASSERT(a_no_write_in_scan, (state_r == S_SCAN) |-> !ram_we, "owner map written during scan")

endmodule

`default_nettype wire
